// ===== rtl/frlm_pkg.sv =====
// Shared constants, the frame record type and the back-end state type
// for the frame RMS level meter. Depends on nothing.
`default_nettype none

package frlm_pkg;

  localparam int unsigned MAX_FRAME   = 1024;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned PROD_W      = 2 * SAMPLE_W;
  // counter must hold MAX_FRAME itself
  localparam int unsigned CNT_W       = $clog2(MAX_FRAME + 1);
  // largest square is 2^30, so MAX_FRAME of them fit in 31 + clog2 bits
  localparam int unsigned SUM_W       = 31 + $clog2(MAX_FRAME);
  localparam int unsigned MEAN_W      = 32;
  localparam int unsigned ROOT_W      = MEAN_W / 2;
  localparam int unsigned SREM_W      = ROOT_W + 2;
  localparam int unsigned LEVEL_W     = 16;
  localparam int unsigned FRAME_CNT_W = 11;
  localparam int unsigned DIV_CNT_W   = $clog2(SUM_W + 1);
  localparam int unsigned SQRT_STEPS  = MEAN_W / 2;
  // queue depth must be a power of two (pointers wrap naturally)
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [SUM_W-1:0] square_sum;
    logic [CNT_W-1:0] sample_total;
    logic             cut_short;
  } frame_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_OUT
  } back_state_e;

endpackage

`default_nettype wire

// ===== rtl/frlm_front.sv =====
// Front end: takes sample beats, squares them, accumulates and closes frames.
// Depends on frlm_pkg.
`default_nettype none

module frlm_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [frlm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                last_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  output frlm_pkg::frame_t                    frame_o,
  output logic                                frame_push_o,
  input  logic                                queue_full_i
);
  import frlm_pkg::*;

  logic [SAMPLE_W-1:0] raw;
  logic [SAMPLE_W-1:0] mag;
  logic                accept;

  logic                s1_valid_q, s1_valid_d;
  logic [PROD_W-1:0]   s1_prod_q;
  logic                s1_last_q;

  logic [SUM_W-1:0]    sum_q, sum_d, sum_next;
  logic [CNT_W-1:0]    cnt_q, cnt_d, cnt_next;
  logic                s1_full, s1_end, consume;

  // -32768 gives 0x8000, i.e. 32768 unsigned
  assign raw    = sample_i;
  assign mag    = raw[SAMPLE_W-1] ? (~raw + SAMPLE_W'(1)) : raw;
  assign accept = in_valid_i && in_ready_o;

  assign sum_next = sum_q + SUM_W'(s1_prod_q);
  assign cnt_next = cnt_q + CNT_W'(1);
  assign s1_full  = (cnt_q == CNT_W'(MAX_FRAME - 1));
  assign s1_end   = s1_last_q || s1_full;
  assign consume  = s1_valid_q && !(s1_end && queue_full_i);

  assign in_ready_o = !s1_valid_q || consume;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (consume) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (consume) begin
      if (s1_end) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_next;
        cnt_d = cnt_next;
      end
    end
  end

  assign frame_push_o         = consume && s1_end;
  assign frame_o.square_sum   = sum_next;
  assign frame_o.sample_total = cnt_next;
  assign frame_o.cut_short    = s1_full && !s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      sum_q      <= '0;
      cnt_q      <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      sum_q      <= sum_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_prod_q <= PROD_W'(mag) * PROD_W'(mag);
      s1_last_q <= last_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/frlm_queue.sv =====
// Short queue of closed frames between the front and back ends.
// Depends on frlm_pkg.
`default_nettype none

module frlm_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  frlm_pkg::frame_t push_data_i,
  input  logic             push_i,
  output logic             full_o,
  output frlm_pkg::frame_t pop_data_o,
  input  logic             pop_i,
  output logic             empty_o
);
  import frlm_pkg::*;

  frame_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  count_q, count_d;
  logic               do_push, do_pop;

  assign full_o     = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/frlm_back.sv =====
// Back end: restoring divide of the square sum by the count, then a
// digit-by-digit square root, one bit per cycle each. Depends on frlm_pkg.
`default_nettype none

module frlm_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  frlm_pkg::frame_t                 frame_i,
  input  logic                             queue_empty_i,
  output logic                             pop_o,
  output logic [frlm_pkg::LEVEL_W-1:0]     rms_level_o,
  output logic [frlm_pkg::FRAME_CNT_W-1:0] frame_count_o,
  output logic                             cut_short_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i
);
  import frlm_pkg::*;

  back_state_e state_q, state_d;

  logic [DIV_CNT_W-1:0] step_q;
  logic [SUM_W-1:0]     dvd_q;      // dividend, becomes the quotient
  logic [CNT_W-1:0]     rem_q;
  logic [CNT_W-1:0]     divisor_q;
  logic                 cut_q;
  logic [MEAN_W-1:0]    rad_q;
  logic [SREM_W-1:0]    srem_q;
  logic [ROOT_W-1:0]    root_q;

  logic                 div_last, sqrt_last;
  logic                 load, div_run, sqrt_run;

  logic [CNT_W:0]       div_sh, div_diff;
  logic                 div_ge;
  logic [SREM_W+1:0]    sq_sh, sq_trial, sq_diff;
  logic                 sq_ge;

  assign div_last  = (step_q == DIV_CNT_W'(SUM_W - 1));
  assign sqrt_last = (step_q == DIV_CNT_W'(SQRT_STEPS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (!queue_empty_i) state_d = BK_DIV;
      BK_DIV:  if (div_last) state_d = BK_SQRT;
      BK_SQRT: if (sqrt_last) state_d = BK_OUT;
      BK_OUT:  if (out_ready_i) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    load        = 1'b0;
    div_run     = 1'b0;
    sqrt_run    = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      BK_IDLE: load        = !queue_empty_i;
      BK_DIV:  div_run     = 1'b1;
      BK_SQRT: sqrt_run    = 1'b1;
      BK_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign pop_o = load;

  // remainder stays below the divisor, so one extra bit covers the shift
  assign div_sh   = {rem_q, dvd_q[SUM_W-1]};
  assign div_diff = div_sh - {1'b0, divisor_q};
  assign div_ge   = (div_sh >= {1'b0, divisor_q});

  assign sq_sh    = {srem_q, rad_q[MEAN_W-1 -: 2]};
  assign sq_trial = (SREM_W + 2)'({root_q, 2'b01});
  assign sq_diff  = sq_sh - sq_trial;
  assign sq_ge    = (sq_sh >= sq_trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (load || (div_run && div_last) || (sqrt_run && sqrt_last)) begin
        step_q <= '0;
      end else if (div_run || sqrt_run) begin
        step_q <= step_q + DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dvd_q     <= frame_i.square_sum;
      rem_q     <= '0;
      divisor_q <= frame_i.sample_total;
      cut_q     <= frame_i.cut_short;
    end else if (div_run) begin
      dvd_q <= {dvd_q[SUM_W-2:0], div_ge};
      rem_q <= div_ge ? div_diff[CNT_W-1:0] : div_sh[CNT_W-1:0];
      if (div_last) begin
        // mean is at most 2^30, so the quotient fits the radicand
        rad_q  <= MEAN_W'({dvd_q[SUM_W-2:0], div_ge});
        srem_q <= '0;
        root_q <= '0;
      end
    end else if (sqrt_run) begin
      rad_q  <= {rad_q[MEAN_W-3:0], 2'b00};
      srem_q <= sq_ge ? sq_diff[SREM_W-1:0] : sq_sh[SREM_W-1:0];
      root_q <= {root_q[ROOT_W-2:0], sq_ge};
    end
  end

  assign rms_level_o   = LEVEL_W'(root_q);
  assign frame_count_o = FRAME_CNT_W'(divisor_q);
  assign cut_short_o   = cut_q;

endmodule

`default_nettype wire

// ===== rtl/frame_rms_level_meter_top.sv =====
// Frame RMS level meter: front end, frame queue and divide/root back end.
// Depends on frlm_pkg, frlm_front, frlm_queue, frlm_back.
//
// Use: signed 16-bit samples arrive on the input channel (in_valid_i /
// in_ready_o) with last_i marking the final sample of a frame. A frame also
// closes when it reaches MAX_FRAME samples, in which case cut_short_o is set
// unless that sample carried last_i. One result beat per frame leaves on the
// output channel (out_valid_o / out_ready_i): rms_level_o is
// floor(sqrt(floor(sum of squares / count))), frame_count_o the frame size.
// Throughput: the front end takes one sample per cycle while the queue can
// take a closing frame (one 16x16 multiply, registered, then a 41-bit
// accumulate). The back end picks up a frame, runs a restoring division over
// SUM_W (41) quotient bits and a square root over 16 root bits, then holds
// the result beat; it takes the next frame only once that beat is accepted.
// Two closed frames can wait in the queue; while both slots are full and
// another frame closes, the input stalls. A stalled receiver holds the
// result steady and the back end waits, while the front end keeps
// accumulating until the queue fills.
// Reset clears the accumulator, the count, the queue and the back end.
`default_nettype none

module frame_rms_level_meter_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic signed [frlm_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic                                   last_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  output logic [frlm_pkg::LEVEL_W-1:0]           rms_level_o,
  output logic [frlm_pkg::FRAME_CNT_W-1:0]       frame_count_o,
  output logic                                   cut_short_o,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i
);
  import frlm_pkg::*;

  frame_t push_frame, pop_frame;
  logic   push, pop, q_full, q_empty;

  frlm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_i     (sample_i),
    .last_i       (last_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .frame_o      (push_frame),
    .frame_push_o (push),
    .queue_full_i (q_full)
  );

  frlm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_data_i (push_frame),
    .push_i      (push),
    .full_o      (q_full),
    .pop_data_o  (pop_frame),
    .pop_i       (pop),
    .empty_o     (q_empty)
  );

  frlm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_i       (pop_frame),
    .queue_empty_i (q_empty),
    .pop_o         (pop),
    .rms_level_o   (rms_level_o),
    .frame_count_o (frame_count_o),
    .cut_short_o   (cut_short_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

endmodule

`default_nettype wire

// ===== rtl/frlm_checker.sv =====
// Port-level checks on the frame RMS level meter, bound to the top level.
// Depends on frlm_pkg and frame_rms_level_meter_top.
`default_nettype none

module frlm_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [frlm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 last_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_o,
  input  logic [frlm_pkg::LEVEL_W-1:0]         rms_level_o,
  input  logic [frlm_pkg::FRAME_CNT_W-1:0]     frame_count_o,
  input  logic                                 cut_short_o,
  input  logic                                 out_valid_o,
  input  logic                                 out_ready_i
);
  import frlm_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rms_level_o)
      && $stable(frame_count_o) && $stable(cut_short_o))
    else $error("result beat changed while stalled");

  a_no_result_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result beat straight out of reset");

  a_frame_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frame_count_o != '0)
    else $error("empty frame reported");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rms_level_o <= LEVEL_W'(32768))
    else $error("level above full scale");

  a_cut_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cut_short_o |-> frame_count_o == FRAME_CNT_W'(MAX_FRAME))
    else $error("cut-short frame not at the size limit");

endmodule

bind frame_rms_level_meter_top frlm_checker u_frlm_checker (.*);

`default_nettype wire
